### rtl/rpat_pkg.sv
// Shared types and constants for the retransmit pending-ack table.
// No dependencies; imported by rpat_ctrl, rpat_datapath and the top level.
package rpat_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int IDX_W         = $clog2(PENDING_DEPTH);
  localparam int CNT_W         = 6;
  localparam int SEQ_W         = 16;
  localparam int STAMP_W       = 32;
  localparam int TMO_W         = 16;
  localparam int KIND_W        = 2;
  localparam int CODE_W        = 3;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [CNT_W-1:0] DEPTH_CNT     = CNT_W'(PENDING_DEPTH);

  localparam logic [KIND_W-1:0] KIND_SENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [CODE_W-1:0] CODE_ADDED     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_FULL      = 3'd1;
  localparam logic [CODE_W-1:0] CODE_REMOVED   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_NOT_FOUND = 3'd3;
  localparam logic [CODE_W-1:0] CODE_RETX      = 3'd4;
  localparam logic [CODE_W-1:0] CODE_TICK_DONE = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic              capture;   // latch request, rewind scan pointer
    logic              tick_adv;  // advance time
    logic              scan;      // issue next table read
    logic              append;    // write new entry at tail
    logic              shift_wr;  // move read entry down one slot
    logic              restamp;   // restamp the read entry
    logic              remove;    // drop one entry from the count
    logic              emit;      // load output register
    logic [CODE_W-1:0] code;
  } rpat_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic dv;            // read data valid for an in-range entry
    logic match;         // read sequence equals request
    logic expired;       // read entry older than timeout
    logic ptr_in_range;  // scan pointer below occupancy
  } rpat_sts_t;

endpackage

### rtl/rpat_ctrl.sv
// Controller state machine of the retransmit pending-ack table.
// Depends on rpat_pkg; drives rpat_datapath through rpat_cmd_t.
module rpat_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpat_pkg::KIND_W-1:0] in_kind,
  input  rpat_pkg::rpat_sts_t       sts,
  output rpat_pkg::rpat_cmd_t       cmd,
  output logic                      busy
);
  import rpat_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SENT      = 3'd1;
  localparam logic [2:0] S_ACK_SCAN  = 3'd2;
  localparam logic [2:0] S_ACK_SHIFT = 3'd3;
  localparam logic [2:0] S_TICK_SCAN = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_kind)
            KIND_SENT: begin
              cmd.capture = 1'b1;
              state_nxt   = S_SENT;
            end
            KIND_ACK: begin
              cmd.capture = 1'b1;
              state_nxt   = S_ACK_SCAN;
            end
            KIND_TICK: begin
              cmd.capture  = 1'b1;
              cmd.tick_adv = 1'b1;
              state_nxt    = S_TICK_SCAN;
            end
            default: ;  // unused kind: no effect, no result
          endcase
        end
      end
      S_SENT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.full) begin
          cmd.code = CODE_FULL;
        end else begin
          cmd.append = 1'b1;
          cmd.code   = CODE_ADDED;
        end
      end
      S_ACK_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.dv && sts.match) begin
          state_nxt = S_ACK_SHIFT;
        end else if (!sts.dv && !sts.ptr_in_range) begin
          cmd.emit  = 1'b1;
          cmd.code  = CODE_NOT_FOUND;
          state_nxt = S_IDLE;
        end
      end
      S_ACK_SHIFT: begin
        cmd.scan = 1'b1;
        if (sts.dv) begin
          cmd.shift_wr = 1'b1;
        end else begin
          cmd.remove = 1'b1;
          cmd.emit   = 1'b1;
          cmd.code   = CODE_REMOVED;
          state_nxt  = S_IDLE;
        end
      end
      S_TICK_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.dv && sts.expired) begin
          cmd.restamp = 1'b1;
          cmd.emit    = 1'b1;
          cmd.code    = CODE_RETX;
        end else if (!sts.dv && !sts.ptr_in_range) begin
          cmd.emit  = 1'b1;
          cmd.code  = CODE_TICK_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/rpat_datapath.sv
// Datapath of the retransmit pending-ack table: entry memories, counters,
// timer, timeout register and result register. Depends on rpat_pkg.
module rpat_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rpat_pkg::SEQ_W-1:0]  in_sequence_req,
  input  logic                        cfg_we,
  input  logic [rpat_pkg::TMO_W-1:0]  cfg_wdata,
  input  rpat_pkg::rpat_cmd_t         cmd,
  output rpat_pkg::rpat_sts_t         sts,
  output logic                        out_strobe,
  output logic [rpat_pkg::CODE_W-1:0] out_code,
  output logic [rpat_pkg::SEQ_W-1:0]  out_chunk_number,
  output logic [rpat_pkg::CNT_W-1:0]  out_pending_total,
  output logic                        out_last
);
  import rpat_pkg::*;

  logic [SEQ_W-1:0]   seq_mem   [PENDING_DEPTH];
  logic [STAMP_W-1:0] stamp_mem [PENDING_DEPTH];

  logic [SEQ_W-1:0]   rd_seq_r;
  logic [STAMP_W-1:0] rd_stamp_r;

  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [STAMP_W-1:0] now_r, now_nxt;
  logic [TMO_W-1:0]   timeout_r, timeout_nxt;
  logic [SEQ_W-1:0]   req_r;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   data_idx_r;
  logic               dv_r, dv_nxt;

  logic               out_strobe_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [SEQ_W-1:0]   out_chunk_r;
  logic [CNT_W-1:0]   out_pending_r;

  logic               ptr_in_range;
  logic [STAMP_W-1:0] age;
  logic [CNT_W-1:0]   shift_dst;
  logic [SEQ_W-1:0]   chunk_sel;

  logic               seq_we, stamp_we;
  logic [IDX_W-1:0]   seq_waddr, stamp_waddr, rd_addr;
  logic [SEQ_W-1:0]   seq_wdata;
  logic [STAMP_W-1:0] stamp_wdata;

  assign ptr_in_range = (ptr_r < occ_r);
  assign age          = now_r - rd_stamp_r;
  assign shift_dst    = data_idx_r - CNT_W'(1);
  assign rd_addr      = ptr_r[IDX_W-1:0];

  assign sts.full         = (occ_r >= DEPTH_CNT);
  assign sts.dv           = dv_r;
  assign sts.match        = (rd_seq_r == req_r);
  assign sts.expired      = (age > {{(STAMP_W-TMO_W){1'b0}}, timeout_r});
  assign sts.ptr_in_range = ptr_in_range;

  // write port steering
  always_comb begin
    seq_we      = cmd.append | cmd.shift_wr;
    stamp_we    = cmd.append | cmd.shift_wr | cmd.restamp;
    seq_waddr   = occ_r[IDX_W-1:0];
    seq_wdata   = req_r;
    stamp_waddr = occ_r[IDX_W-1:0];
    stamp_wdata = now_r;
    if (cmd.shift_wr) begin
      seq_waddr   = shift_dst[IDX_W-1:0];
      seq_wdata   = rd_seq_r;
      stamp_waddr = shift_dst[IDX_W-1:0];
      stamp_wdata = rd_stamp_r;
    end else if (cmd.restamp) begin
      stamp_waddr = data_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[seq_waddr] <= seq_wdata;
    end
    rd_seq_r <= seq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    rd_stamp_r <= stamp_mem[rd_addr];
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.append) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (cmd.remove) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
    now_nxt     = cmd.tick_adv ? now_r + STAMP_W'(1) : now_r;
    timeout_nxt = cfg_we ? cfg_wdata : timeout_r;
    ptr_nxt     = ptr_r;
    dv_nxt      = cmd.scan & ptr_in_range;
    if (cmd.capture) begin
      ptr_nxt = '0;
      dv_nxt  = 1'b0;
    end else if (cmd.scan && ptr_in_range) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.code)
      CODE_RETX:      chunk_sel = rd_seq_r;
      CODE_TICK_DONE: chunk_sel = '0;
      default:        chunk_sel = req_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= '0;
      now_r        <= '0;
      timeout_r    <= TIMEOUT_RESET;
      ptr_r        <= '0;
      dv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      occ_r        <= occ_nxt;
      now_r        <= now_nxt;
      timeout_r    <= timeout_nxt;
      ptr_r        <= ptr_nxt;
      dv_r         <= dv_nxt;
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    data_idx_r <= ptr_r;
    if (cmd.capture) begin
      req_r <= in_sequence_req;
    end
    if (cmd.emit) begin
      out_code_r    <= cmd.code;
      out_chunk_r   <= chunk_sel;
      out_pending_r <= occ_nxt;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_code          = out_code_r;
  assign out_chunk_number  = out_chunk_r;
  assign out_pending_total = out_pending_r;
  assign out_last          = (out_code_r != CODE_RETX);

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_CNT) else $error("occupancy beyond table depth");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full) else $error("append into full table");

  a_shift_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> (dv_r && data_idx_r != '0 && data_idx_r < occ_r))
    else $error("shift write without a valid in-range entry");

  a_restamp_expired: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restamp |-> (dv_r && sts.expired && data_idx_r < occ_r))
    else $error("restamp of an entry that is not expired");
`endif

endmodule

### rtl/retransmit_pending_ack_table.sv
// Retransmit pending-ack table, top level: rpat_ctrl plus rpat_datapath (rpat_pkg).
// A sent item gives one result; an ack or a tick walks the table and ends with
//   a final result. busy is high while an item is worked on, and a new item is
//   taken only while busy is low; the walk reads one entry per cycle through one
//   read address shared by the sequence and stamp memories.
// Reset (rst_n low, sync): empty table, time 0, timeout 100; no stall input.
module retransmit_pending_ack_table (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item
  input  logic                        start,
  output logic                        busy,
  input  logic [rpat_pkg::KIND_W-1:0] in_kind,
  input  logic [rpat_pkg::SEQ_W-1:0]  in_sequence_req,
  // timeout register
  input  logic                        cfg_we,
  input  logic [rpat_pkg::TMO_W-1:0]  cfg_wdata,
  // result items
  output logic                        out_strobe,
  output logic [rpat_pkg::CODE_W-1:0] out_code,
  output logic [rpat_pkg::SEQ_W-1:0]  out_chunk_number,
  output logic [rpat_pkg::CNT_W-1:0]  out_pending_total,
  output logic                        out_last
);
  import rpat_pkg::*;

  // command and status between the two halves
  rpat_cmd_t cmd;
  rpat_sts_t sts;

  // Sequencer: decodes the item kind at transfer; sent appends, ack and tick walk
  // the table: ack = search then close the gap, tick = age check and restamp.
  rpat_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Entry memories (sequence, stamp), occupancy, tick counter, timeout and
  // the output register. Every result leaves through that register.
  rpat_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sequence_req   (in_sequence_req),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_strobe        (out_strobe),
    .out_code          (out_code),
    .out_chunk_number  (out_chunk_number),
    .out_pending_total (out_pending_total),
    .out_last          (out_last)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the retransmit pending-ack table: sent, ack, tick and
// unused items under several timeout settings, checked against a local predictor.
// Depends on rpat_pkg and the retransmit_pending_ack_table top level only.
module tb_top;
  import rpat_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 4;
  // Kind 3 leaves no result to wait on, so every quiet point also lets this many
  // cycles go by, enough for the longest busy stretch of a full-table walk.
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int NUM_PHASES      = 6;
  // Kind with no meaning: the block must drop it without a result.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
  } table_op_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SEQ_W-1:0]  chunk;
    logic [CNT_W-1:0]  pending;
    logic              last;
  } table_result_t;

  // DUT ports
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] in_kind         = '0;
  logic [SEQ_W-1:0]  in_sequence_req = '0;
  logic              cfg_we          = 1'b0;
  logic [TMO_W-1:0]  cfg_wdata       = '0;
  logic              out_strobe;
  logic [CODE_W-1:0] out_code;
  logic [SEQ_W-1:0]  out_chunk_number;
  logic [CNT_W-1:0]  out_pending_total;
  logic              out_last;

  // Predicted table: sequence and send stamp per slot, fill level, clock, timeout.
  logic [SEQ_W-1:0]   pred_seq   [PENDING_DEPTH];
  logic [STAMP_W-1:0] pred_stamp [PENDING_DEPTH];
  logic [CNT_W-1:0]   pred_count   = '0;
  logic [STAMP_W-1:0] pred_now     = '0;
  logic [TMO_W-1:0]   pred_timeout = TIMEOUT_RESET;

  table_result_t    expected_results [$];  // results owed by the DUT, oldest first
  table_op_t        op_queue [$];          // items waiting for the driver
  logic [SEQ_W-1:0] queued_seqs [$];       // table contents as seen by the generator
  int               ops_in_flight   = 0;   // queued but not yet transferred
  int               err_cnt         = 0;
  int               cycle_count     = 0;
  int               sender_idle_pct = 37;
  logic             item_taken      = 1'b0;

  logic [TMO_W-1:0] phase_timeouts [NUM_PHASES] =
    '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd12, 16'd5};

  retransmit_pending_ack_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_sequence_req   (in_sequence_req),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_code          (out_code),
    .out_chunk_number  (out_chunk_number),
    .out_pending_total (out_pending_total),
    .out_last          (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Every result carries the fill level after the step.
  function automatic table_result_t result_now(input logic [CODE_W-1:0] code,
                                               input logic [SEQ_W-1:0] chunk,
                                               input logic last);
    table_result_t r;
    r.code    = code;
    r.chunk   = chunk;
    r.pending = pred_count;
    r.last    = last;
    return r;
  endfunction

  task automatic predict_table_op(input table_op_t op);
    int                 hit;
    logic [STAMP_W-1:0] age;
    hit = -1;
    case (op.kind)
      KIND_SENT: begin
        if (pred_count == DEPTH_CNT) begin
          expected_results.push_back(result_now(CODE_FULL, op.seq, 1'b1));
        end else begin
          pred_seq[pred_count]   = op.seq;
          pred_stamp[pred_count] = pred_now;
          pred_count             = pred_count + 1'b1;
          expected_results.push_back(result_now(CODE_ADDED, op.seq, 1'b1));
        end
      end
      KIND_ACK: begin
        // only the oldest matching slot goes; the slots above it slide down one
        for (int i = 0; i < pred_count && hit < 0; i++)
          if (pred_seq[i] == op.seq) hit = i;
        if (hit < 0) begin
          expected_results.push_back(result_now(CODE_NOT_FOUND, op.seq, 1'b1));
        end else begin
          for (int j = hit; j + 1 < pred_count; j++) begin
            pred_seq[j]   = pred_seq[j + 1];
            pred_stamp[j] = pred_stamp[j + 1];
          end
          pred_count = pred_count - 1'b1;
          expected_results.push_back(result_now(CODE_REMOVED, op.seq, 1'b1));
        end
      end
      KIND_TICK: begin
        pred_now = pred_now + 1'b1;
        for (int i = 0; i < pred_count; i++) begin
          age = pred_now - pred_stamp[i];  // modulo 2^32
          if (age > STAMP_W'(pred_timeout)) begin
            pred_stamp[i] = pred_now;
            expected_results.push_back(result_now(CODE_RETX, pred_seq[i], 1'b0));
          end
        end
        expected_results.push_back(result_now(CODE_TICK_DONE, '0, 1'b1));
      end
      default: ;  // unused kind: no state change, no result
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item per transfer, random sender gaps between items
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : op_driver
    table_op_t op;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (op_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        op = op_queue.pop_front();
        start           <= 1'b1;
        in_kind         <= op.kind;
        in_sequence_req <= op.seq;
      end else begin
        // idle: payload is junk and must be ignored
        start           <= 1'b0;
        in_kind         <= KIND_W'($urandom);
        in_sequence_req <= SEQ_W'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result check, transfer capture, timeout register tracking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    table_result_t want;
    table_op_t     op;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing pending: code %0d chunk 0x%0h pending %0d last %0b",
                 out_code, out_chunk_number, out_pending_total, out_last);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("code", 32'(want.code), 32'(out_code));
          check_field("chunk_number", 32'(want.chunk), 32'(out_chunk_number));
          check_field("pending_total", 32'(want.pending), 32'(out_pending_total));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end else if (out_strobe !== 1'b0) begin
        $error("out_strobe unknown: %b", out_strobe);
        err_cnt++;
      end
      // results trail their item through the state and output registers, so order here is free
      if (start && busy === 1'b0) begin
        op.kind = in_kind;
        op.seq  = in_sequence_req;
        predict_table_op(op);
        ops_in_flight--;
      end
      if (cfg_we) pred_timeout = cfg_wdata;
      item_taken <= start && busy === 1'b0;
    end else begin
      item_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Queue one item and mirror its effect on the table contents so that later
  // acks can target sequences that are really present.
  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq);
    table_op_t op;
    int        hit;
    hit     = -1;
    op.kind = kind;
    op.seq  = seq;
    op_queue.push_back(op);
    ops_in_flight++;
    if (kind == KIND_SENT && queued_seqs.size() < PENDING_DEPTH) begin
      queued_seqs.push_back(seq);
    end else if (kind == KIND_ACK) begin
      for (int i = 0; i < queued_seqs.size() && hit < 0; i++)
        if (queued_seqs[i] == seq) hit = i;
      if (hit >= 0) queued_seqs.delete(hit);
    end
  endtask

  // Small pool for duplicates, the extremes, and full-range values.
  function automatic logic [SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return SEQ_W'($urandom_range(0, 7));
    if (r < 40) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return SEQ_W'($urandom);
  endfunction

  // Mostly a sequence that is in the table, else anything.
  function automatic logic [SEQ_W-1:0] pick_ack_seq();
    if (queued_seqs.size() != 0 && $urandom_range(0, 3) != 0)
      return queued_seqs[$urandom_range(0, queued_seqs.size() - 1)];
    return pick_seq();
  endfunction

  task automatic queue_random_ops(input int n);
    int made, r, k;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        // fill to the top with a few ticks mixed in, then push past full
        while (queued_seqs.size() < PENDING_DEPTH) begin
          if ($urandom_range(0, 5) == 0) queue_op(KIND_TICK, SEQ_W'($urandom));
          else queue_op(KIND_SENT, pick_seq());
          made++;
        end
        k = $urandom_range(1, 3);
        repeat (k) begin
          queue_op(KIND_SENT, pick_seq());
          made++;
        end
      end else if (r < 40) begin
        // run of acks, mostly of queued sequences, with ticks in between
        k = $urandom_range(4, 16);
        repeat (k) begin
          if ($urandom_range(0, 4) == 0) queue_op(KIND_TICK, SEQ_W'($urandom));
          else queue_op(KIND_ACK, pick_ack_seq());
          made++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          queue_op(KIND_SENT, pick_seq());
          made++;
        end else if (r < 62) begin
          queue_op(KIND_ACK, pick_ack_seq());
          made++;
        end else if (r < 93) begin
          queue_op(KIND_TICK, SEQ_W'($urandom));
          made++;
        end else begin
          queue_op(KIND_UNUSED, SEQ_W'($urandom));
        end
      end
    end
  endtask

  // Sender holds off until every item is through and every result is back.
  task automatic wait_table_quiet();
    while (ops_in_flight != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge with the block idle.
  task automatic write_timeout(input logic [TMO_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timeout of 100: adds, duplicate, quiet tick, ignored kind, acks.
    queue_op(KIND_SENT, 16'h0000);
    queue_op(KIND_SENT, 16'hFFFF);
    queue_op(KIND_SENT, 16'hA5A5);
    queue_op(KIND_SENT, 16'hA5A5);
    queue_op(KIND_TICK, 16'h0000);
    queue_op(KIND_UNUSED, 16'hFFFF);
    queue_op(KIND_UNUSED, 16'h0000);
    queue_op(KIND_ACK, 16'hA5A5);
    queue_op(KIND_ACK, 16'h1234);
    wait_table_quiet();

    // Zero timeout: each tick retransmits every entry older than now.
    write_timeout('0);
    @(posedge clk);
    queue_op(KIND_TICK, 16'hFFFF);
    queue_op(KIND_SENT, 16'h5A5A);
    queue_op(KIND_TICK, 16'h0000);
    queue_op(KIND_ACK, 16'hA5A5);
    queue_op(KIND_ACK, 16'hA5A5);
    queue_op(KIND_ACK, 16'h0000);
    queue_op(KIND_ACK, 16'hFFFF);
    queue_op(KIND_ACK, 16'h5A5A);
    queue_op(KIND_TICK, 16'h5A5A);
    queue_op(KIND_ACK, 16'h0000);
    wait_table_quiet();

    // Random phases: sender gaps 37%, then 74%, then back to back.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_timeout(phase_timeouts[ph]);
      sender_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 74 : 0;
      @(posedge clk);
      queue_random_ops(ITEMS_PER_PHASE);
      wait_table_quiet();
    end

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rpat_pkg.sv
rtl/rpat_ctrl.sv
rtl/rpat_datapath.sv
rtl/retransmit_pending_ack_table.sv
dv/tb_top.sv
